// ===== sv/bml_pkg.sv =====
// Shared constants, types and coefficient tables of the Box-Muller normal generator.
`default_nettype none

package bml_pkg;

  // Default widths
  localparam int unsigned UNIFORM_BITS_DEF  = 32;
  localparam int unsigned OUT_FRAC_BITS_DEF = 13;

  // Output sample and stream widths
  localparam int unsigned OUT_W        = 17;
  localparam int unsigned OUT_TDATA_W  = ((2 * OUT_W + 7) / 8) * 8;
  localparam logic [16:0] OUT_MAX_POS  = 17'd65535;
  localparam logic [16:0] OUT_MAX_NEG  = 17'd65536;

  // Logarithm datapath
  localparam int unsigned LOG_FRAC     = 28;
  localparam int unsigned MANT_W       = LOG_FRAC + 1;
  localparam logic [28:0] TWO_LN2_Q28  = 29'd372130559;

  // Trigonometric datapath
  localparam int unsigned TRIG_FRAC    = 30;
  localparam int unsigned TRIG_W       = TRIG_FRAC + 1;
  localparam logic [30:0] TRIG_ONE     = 31'h4000_0000;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam int unsigned SIN_STEPS    = 5;
  localparam int unsigned COS_STEPS    = 6;
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

  // Quadrant of the angle
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Angle placement carried from the front cell to the trig end
  typedef struct packed {
    quad_e quad;
    logic  swap;
  } angle_sel_t;

  // Signed trig magnitudes waiting for the radius
  typedef struct packed {
    logic              cneg;
    logic              sneg;
    logic [TRIG_W-1:0] cm;
    logic [TRIG_W-1:0] sm;
  } trig_sel_t;

endpackage

`default_nettype wire

// ===== sv/box_muller_gaussian.sv =====
// Top level of the pipelined Box-Muller normal sample generator.
//
//  Channel   Dir  Fields (lowest bit up)                 Beat taken when
//  s_axis    in   uniform_a, uniform_b                   tvalid & tready
//  m_axis    out  normal_cos, normal_sin, zero fill      tvalid & tready
//
//  One beat in and one beat out per cycle while the output queue has a free entry.
//  An accepted beat passes the front cell, the 28 log cells, the log and scaling
//  registers, the square-root cells and the product register in series; the write
//  into the output queue then raises tvalid.
//  Reset clears the valid chain and the two-entry output queue; no pass is needed.
//  The whole row advances while the output queue has a free entry, so one waiting
//  result never stops intake.
`default_nettype none

module box_muller_gaussian #(
  parameter int unsigned UNIFORM_BITS  = bml_pkg::UNIFORM_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS = bml_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // uniform_a, uniform_b, zero fill
  input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0]   s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // normal_cos, normal_sin, zero fill
  output logic [bml_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o
);
  import bml_pkg::*;

  localparam int unsigned UW       = UNIFORM_BITS;
  localparam int unsigned P_W      = $clog2(UW);
  localparam int unsigned LG_W     = $clog2(UW + 1) + LOG_FRAC;
  localparam int unsigned LGI_W    = LG_W - LOG_FRAC;
  localparam int unsigned R2_W     = LG_W + 1;
  localparam int unsigned V_W      = R2_W + LOG_FRAC;
  localparam int unsigned RS       = (V_W + 1) / 2;
  localparam int unsigned L_RAD    = 1 + LOG_FRAC + 2 + RS;
  localparam int unsigned N_PIPE   = L_RAD + 1;
  localparam int unsigned TRIG_LAT = 3 + 3 * COS_STEPS;
  localparam int unsigned SIN_DLY  = 3 * (COS_STEPS - SIN_STEPS) - 1;
  localparam int unsigned X_DLY    = 3 * SIN_STEPS + 1;
  localparam int unsigned TRIG_DLY = L_RAD - TRIG_LAT;
  localparam int unsigned PW       = RS + TRIG_W;
  localparam int unsigned SH       = LOG_FRAC + TRIG_FRAC - OUT_FRAC_BITS;
  localparam int unsigned PAIR_W   = 2 * OUT_W;

  // Flow control
  logic              en;
  logic [N_PIPE-1:0] vld_q;
  logic              push, pop;
  logic [1:0]        cnt_q, cnt_d;
  logic              wr_ptr_q, rd_ptr_q;
  logic [PAIR_W-1:0] fifo_q [2];

  // Front cell
  logic [UW-1:0]        u1_raw, u1, u2, norm;
  logic [UW+MANT_W-1:0] normw;
  logic [P_W-1:0]       p_lod, sh_amt;
  logic [UW+31:0]       phw;
  logic [31:0]          ph;
  logic [29:0]          r_ang;
  logic                 swap_d;
  logic [29:0]          t_d;
  logic [MANT_W-1:0]    m_q;
  logic [P_W-1:0]       p_q;
  logic [29:0]          t_q;
  angle_sel_t           asel_q, asel_end;

  // Log chain
  logic [MANT_W-1:0]   lm [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] lf [LOG_FRAC+1];
  logic [P_W-1:0]      lp [LOG_FRAC+1];
  logic [LGI_W-1:0]    uwp;
  logic [LG_W-1:0]     lg_q;
  logic [LG_W+28:0]    r2_prod;
  logic [R2_W-1:0]     r2_q;

  // Root chain
  logic [V_W-1:0] sv [RS+1];
  logic [V_W-1:0] sr [RS+1];

  // Trig lanes
  logic [61:0]          x_prod;
  logic [TRIG_FRAC-1:0] x_q, x2_q, x_late;
  logic [2*TRIG_FRAC-1:0] x2_prod;
  logic [TRIG_FRAC-1:0] cx2 [COS_STEPS+1];
  logic [TRIG_W-1:0]    ch  [COS_STEPS+1];
  logic [TRIG_FRAC-1:0] sx2 [SIN_STEPS+1];
  logic [TRIG_W-1:0]    shh [SIN_STEPS+1];
  logic [TRIG_FRAC+TRIG_W-1:0] sin_prod;
  logic [TRIG_W-1:0]    sinf_q, sin_end;
  logic [TRIG_W-1:0]    c0, s0;
  trig_sel_t            tsel_d, tsel_end;

  // Output products
  logic [PW-1:0]     cmag_q, smag_q;
  logic              cneg_q, sneg_q;
  logic [OUT_W-1:0]  cos_out, sin_out;

  // Round half away from zero, saturate, then apply the sign
  function automatic logic [OUT_W-1:0] to_out(input logic [PW-1:0] mag, input logic neg);
    logic [PW:0]      rnd;
    logic [63:0]      v;
    logic [OUT_W-1:0] sat;
    rnd = {1'b0, mag} + ((PW+1)'(1) << (SH - 1));
    v   = 64'(rnd >> SH);
    if (neg) begin
      sat = (v > 64'(OUT_MAX_NEG)) ? OUT_MAX_NEG : v[OUT_W-1:0];
    end else begin
      sat = (v > 64'(OUT_MAX_POS)) ? OUT_MAX_POS : v[OUT_W-1:0];
    end
    return neg ? (OUT_W'(0) - sat) : sat;
  endfunction

  // Advance the row while the output queue has room
  assign en              = (cnt_q != 2'd2);
  assign s_axis_tready_o = en;
  assign push            = en & vld_q[N_PIPE-1];
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_PIPE-2:0], s_axis_tvalid_i};
    end
  end

  // Clamp u1, find its top bit and normalise to Q1.28
  always_comb begin
    u1_raw = s_axis_tdata_i[UW-1:0];
    u1     = (u1_raw == '0) ? UW'(1) : u1_raw;
    p_lod  = '0;
    for (int i = 0; i < UW; i++) begin
      if (u1[i]) p_lod = P_W'(i);
    end
    sh_amt = P_W'(UW - 1) - p_lod;
    norm   = u1 << sh_amt;
    normw  = {norm, {MANT_W{1'b0}}};
  end

  // Scale u2 to a 32-bit turn and fold into the first eighth
  always_comb begin
    u2     = s_axis_tdata_i[2*UW-1:UW];
    phw    = {u2, 32'd0};
    ph     = phw[UW+31 -: 32];
    r_ang  = ph[29:0];
    swap_d = (r_ang > 30'h2000_0000);
    t_d    = swap_d ? 30'(31'h4000_0000 - {1'b0, r_ang}) : r_ang;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q         <= normw[UW+MANT_W-1 -: MANT_W];
      p_q         <= p_lod;
      t_q         <= t_d;
      asel_q.quad <= quad_e'(ph[31:30]);
      asel_q.swap <= swap_d;
    end
  end

  // Log2 cells
  assign lm[0] = m_q;
  assign lf[0] = '0;
  assign lp[0] = p_q;

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
    bml_log_cell #(.IDX(k), .P_W(P_W)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .m_i   (lm[k]),
      .f_i   (lf[k]),
      .p_i   (lp[k]),
      .m_o   (lm[k+1]),
      .f_o   (lf[k+1]),
      .p_o   (lp[k+1])
    );
  end

  // Form -log2(u1), then scale by 2 ln 2
  assign uwp     = LGI_W'(UW) - LGI_W'(lp[LOG_FRAC]);
  assign r2_prod = lg_q * TWO_LN2_Q28;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lg_q <= {uwp, {LOG_FRAC{1'b0}}} - LG_W'(lf[LOG_FRAC]);
      r2_q <= r2_prod[LG_W+28:LOG_FRAC];
    end
  end

  // Square-root cells
  assign sv[0] = {r2_q, {LOG_FRAC{1'b0}}};
  assign sr[0] = '0;

  for (genvar k = 0; k < RS; k++) begin : g_sqrt
    bml_sqrt_cell #(.V_W(V_W), .BIT_POS(2 * (RS - 1 - k))) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (sv[k]),
      .r_i   (sr[k]),
      .v_o   (sv[k+1]),
      .r_o   (sr[k+1])
    );
  end

  // Angle in radians and its square
  assign x_prod  = t_q * PI_Q30;
  assign x2_prod = x_q * x_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= x_prod[60:31];
      x2_q <= x2_prod[2*TRIG_FRAC-1:TRIG_FRAC];
    end
  end

  // Cosine Horner cells
  assign cx2[0] = x2_q;
  assign ch[0]  = TRIG_ONE;

  for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
    bml_horner_cell #(.DIV(COS_DIV[k])) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (cx2[k]),
      .h_i   (ch[k]),
      .x2_o  (cx2[k+1]),
      .h_o   (ch[k+1])
    );
  end

  // Sine Horner cells
  assign sx2[0] = x2_q;
  assign shh[0] = TRIG_ONE;

  for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
    bml_horner_cell #(.DIV(SIN_DIV[k])) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (sx2[k]),
      .h_i   (shh[k]),
      .x2_o  (sx2[k+1]),
      .h_o   (shh[k+1])
    );
  end

  bml_delay #(.W(TRIG_FRAC), .DEPTH(X_DLY)) u_x_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (x_q),
    .q_o   (x_late)
  );

  // Finish the sine with its factor x
  assign sin_prod = x_late * shh[SIN_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sinf_q <= TRIG_W'(sin_prod[2*TRIG_FRAC-1:TRIG_FRAC]);
    end
  end

  bml_delay #(.W(TRIG_W), .DEPTH(SIN_DLY)) u_sin_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sinf_q),
    .q_o   (sin_end)
  );

  bml_delay #(.W($bits(angle_sel_t)), .DEPTH(TRIG_LAT - 1)) u_ang_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (asel_q),
    .q_o   (asel_end)
  );

  // Undo the fold, then place by quadrant
  always_comb begin
    c0 = asel_end.swap ? sin_end : ch[COS_STEPS];
    s0 = asel_end.swap ? ch[COS_STEPS] : sin_end;
    unique case (asel_end.quad)
      QUAD_0: tsel_d = '{cneg: 1'b0, sneg: 1'b0, cm: c0, sm: s0};
      QUAD_1: tsel_d = '{cneg: 1'b1, sneg: 1'b0, cm: s0, sm: c0};
      QUAD_2: tsel_d = '{cneg: 1'b1, sneg: 1'b1, cm: c0, sm: s0};
      QUAD_3: tsel_d = '{cneg: 1'b0, sneg: 1'b1, cm: s0, sm: c0};
      default: tsel_d = '{cneg: 1'b0, sneg: 1'b0, cm: c0, sm: s0};
    endcase
  end

  bml_delay #(.W($bits(trig_sel_t)), .DEPTH(TRIG_DLY)) u_trig_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (tsel_d),
    .q_o   (tsel_end)
  );

  // Radius times trig magnitude
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmag_q <= sr[RS][RS-1:0] * tsel_end.cm;
      smag_q <= sr[RS][RS-1:0] * tsel_end.sm;
      cneg_q <= tsel_end.cneg;
      sneg_q <= tsel_end.sneg;
    end
  end

  assign cos_out = to_out(cmag_q, cneg_q);
  assign sin_out = to_out(smag_q, sneg_q);

  // Two-entry output queue
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {sin_out, cos_out};
    end
  end

  assign m_axis_tdata_o = {{(OUT_TDATA_W - PAIR_W){1'b0}}, fifo_q[rd_ptr_q]};

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("intake stalled with no result waiting");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid chain moved while the row was held");

endmodule

`default_nettype wire

// ===== sv/bml_delay.sv =====
// Enabled shift line of DEPTH registers that delays a word.
`default_nettype none

module bml_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  // Shift one place per advancing cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== sv/bml_log_cell.sv =====
// One fraction bit of log2 of the mantissa by squaring.
`default_nettype none

module bml_log_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned P_W = 5
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [bml_pkg::MANT_W-1:0]    m_i,
  input  logic [bml_pkg::LOG_FRAC-1:0]  f_i,
  input  logic [P_W-1:0]                p_i,
  output logic [bml_pkg::MANT_W-1:0]    m_o,
  output logic [bml_pkg::LOG_FRAC-1:0]  f_o,
  output logic [P_W-1:0]                p_o
);
  import bml_pkg::*;

  localparam logic [LOG_FRAC-1:0] FBIT = LOG_FRAC'(1) << (LOG_FRAC - 1 - IDX);

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_top;
  logic [MANT_W-1:0]   m_d;
  logic [LOG_FRAC-1:0] f_d;
  logic [MANT_W-1:0]   m_q;
  logic [LOG_FRAC-1:0] f_q;
  logic [P_W-1:0]      p_q;

  // Square, then halve and set the bit once the mantissa reaches two
  always_comb begin
    sq     = m_i * m_i;
    sq_top = sq[LOG_FRAC+MANT_W:LOG_FRAC];
    if (sq_top[MANT_W]) begin
      m_d = sq_top[MANT_W:1];
      f_d = f_i | FBIT;
    end else begin
      m_d = sq_top[MANT_W-1:0];
      f_d = f_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
      f_q <= f_d;
      p_q <= p_i;
    end
  end

  assign m_o = m_q;
  assign f_o = f_q;
  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== sv/bml_horner_cell.sv =====
// One Horner step h = 1 - (x2*h)/d over three registered stages.
`default_nettype none

module bml_horner_cell #(
  parameter int unsigned DIV = 2
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [bml_pkg::TRIG_FRAC-1:0] x2_i,
  input  logic [bml_pkg::TRIG_W-1:0]    h_i,
  output logic [bml_pkg::TRIG_FRAC-1:0] x2_o,
  output logic [bml_pkg::TRIG_W-1:0]    h_o
);
  import bml_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
  localparam logic [7:0]  DIV_C = 8'(DIV);

  logic [TRIG_FRAC+TRIG_W-1:0] prod;
  logic [61:0]                 qprod;
  logic [37:0]                 qd;
  logic [37:0]                 rem;
  logic [TRIG_FRAC-1:0]        qc;
  logic [TRIG_FRAC-1:0]        y_q, yb_q, q0_q;
  logic [TRIG_FRAC-1:0]        x2a_q, x2b_q, x2c_q;
  logic [TRIG_W-1:0]           h_q;

  // Product with the running term, then quotient estimate by reciprocal
  assign prod  = x2_i * h_i;
  assign qprod = y_q * RECIP;

  // Correct the estimate by one where the remainder reaches the divisor
  always_comb begin
    qd  = q0_q * DIV_C;
    rem = {8'd0, yb_q} - qd;
    qc  = q0_q + TRIG_FRAC'(rem >= 38'(DIV_C));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q   <= prod[2*TRIG_FRAC-1:TRIG_FRAC];
      x2a_q <= x2_i;
      q0_q  <= qprod[61:32];
      yb_q  <= y_q;
      x2b_q <= x2a_q;
      h_q   <= TRIG_ONE - {1'b0, qc};
      x2c_q <= x2b_q;
    end
  end

  assign x2_o = x2c_q;
  assign h_o  = h_q;

endmodule

`default_nettype wire

// ===== sv/bml_sqrt_cell.sv =====
// One result bit of the integer square root.
`default_nettype none

module bml_sqrt_cell #(
  parameter int unsigned V_W     = 63,
  parameter int unsigned BIT_POS = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [V_W-1:0] v_i,
  input  logic [V_W-1:0] r_i,
  output logic [V_W-1:0] v_o,
  output logic [V_W-1:0] r_o
);

  localparam logic [V_W-1:0] BIT = V_W'(1) << BIT_POS;

  logic [V_W:0]   sum;
  logic           take;
  logic [V_W-1:0] v_d, r_d, v_q, r_q;

  // Subtract the trial value where it fits and fold the bit into the root
  always_comb begin
    sum  = {1'b0, r_i} + {1'b0, BIT};
    take = ({1'b0, v_i} >= sum);
    if (take) begin
      v_d = v_i - sum[V_W-1:0];
      r_d = (r_i >> 1) + BIT;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

`default_nettype wire
